>>> src/kmp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kmp_pkg: shared constants, types and codes of the substring search block
// Sizes of the pattern store and the text counter, word field codes and the
// structs that travel between the engine, the table memory and the top level.
// ----------------------------------------------------------------------------
package kmp_pkg;

	localparam int PATTERN_MAX   = 64;
	localparam int SYMBOL_BITS   = 8;
	localparam int POSITION_BITS = 32;

	localparam int IDX_W = $clog2(PATTERN_MAX);
	localparam int CNT_W = $clog2(PATTERN_MAX + 1);

	// Widths of the fields as they appear on the stream ports.
	localparam int SYMBOL_FIELD_W = 8;
	localparam int MATCH_POS_W    = 32;

	typedef logic [SYMBOL_BITS-1:0]   sym_t;
	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [CNT_W-1:0]         cnt_t;
	// Failure index in two's complement; the top bit set means minus one.
	typedef logic [IDX_W:0]           fail_t;
	typedef logic [POSITION_BITS-1:0] pos_t;

	localparam cnt_t  COUNT_MAX = CNT_W'(PATTERN_MAX);
	localparam fail_t FAIL_NONE = '1;

	localparam logic [1:0] MODE_PATTERN = 2'd0;
	localparam logic [1:0] MODE_TEXT    = 2'd1;
	localparam logic [1:0] MODE_END     = 2'd2;

	localparam logic [2:0] ST_PATTERN_OK = 3'd0;
	localparam logic [2:0] ST_NO_MATCH   = 3'd1;
	localparam logic [2:0] ST_MATCH      = 3'd2;
	localparam logic [2:0] ST_ALREADY    = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND  = 3'd4;
	localparam logic [2:0] ST_OVERFLOW   = 3'd5;

	typedef struct packed {
		logic [1:0] mode;
		sym_t       symbol;
		logic       restart;
	} kmp_item_t;

	typedef struct packed {
		logic [2:0] status;
		pos_t       position;
	} kmp_res_t;

	typedef struct packed {
		sym_t  sym;
		fail_t fail;
	} kmp_entry_t;

	typedef struct packed {
		logic       en;
		idx_t       addr;
		kmp_entry_t data;
	} kmp_wr_t;

	typedef struct packed {
		logic en;
		idx_t addr;
	} kmp_rd_t;

endpackage
`default_nettype wire

>>> src/kmp_substring_search.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kmp_substring_search: streaming first-occurrence substring search
// Builds the failure table while pattern words arrive, then matches text
// words against it and reports the start of the first match.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Fields (lowest bit first)
// s_*       in         tdata: symbol[7:0], restart[8]; tuser: mode[1:0]
// m_*       out        tdata: match_position[31:0]; tuser: status[2:0]
//
// A word with no table walk (overflow, first pattern symbol, empty prefix,
// end of text, already found, empty pattern) is accepted and handed off to
// the output register. A pattern or text word that walks the failure chain
// reads table entries one per cycle through the single read port of the
// table memory before its result is handed off.
// The stores are undefined until written, so reset clears only the state,
// counters and flags, and the block is ready in the first cycle after reset.
// A stalled output holds its word; the engine then finishes the next word
// and waits with it until the output register frees.
//
module kmp_substring_search import kmp_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [15:0] s_tdata,   // symbol[7:0], restart[8], zero[15:9]
	input  wire  [1:0]  s_tuser,   // mode[1:0]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata,   // match_position[31:0]
	output logic [2:0]  m_tuser    // status[2:0]
);

	kmp_item_t  item;
	kmp_res_t   res;
	kmp_res_t   m_res_q;
	logic       m_valid_q;
	logic       res_valid;
	logic       res_ready;
	kmp_wr_t    wr;
	kmp_rd_t    rd;
	kmp_entry_t rd_data;

	// Unpack the input word; only the low symbol bits take part in matching.
	assign item.mode    = s_tuser;
	assign item.symbol  = sym_t'(s_tdata[SYMBOL_FIELD_W-1:0]);
	assign item.restart = s_tdata[SYMBOL_FIELD_W];

	kmp_ram u_ram (
		.clk     (clk),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	// The engine runs one word at a time; its state machine is the interlock
	// that keeps a table write and a later read of the same entry apart.
	kmp_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (s_tvalid),
		.item_ready (s_tready),
		.item       (item),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.wr         (wr),
		.rd         (rd),
		.rd_data    (rd_data)
	);

	// Output register: takes a new result when empty or when being drained.
	assign res_ready = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = MATCH_POS_W'(m_res_q.position);
	assign m_tuser  = m_res_q.status;

	// After a word is taken the engine is busy and not ready in the next cycle.
	a_one_word_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("engine accepted a second word straight after the first");

	// Only a match carries a position; every other status reports zero.
	a_position_only_on_match: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ST_MATCH) |-> (m_tdata == '0))
		else $error("non-zero position on a result that is not a match");

	// A ready engine holds no unfinished result.
	a_ready_means_drained: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !res_valid)
		else $error("engine ready while a result is still pending");

endmodule
`default_nettype wire

>>> src/kmp_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kmp_ram: pattern and failure table memory
// One entry per pattern index holds the symbol and its failure index. One
// write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kmp_ram import kmp_pkg::*; (
	input  wire        clk,
	input  kmp_wr_t    wr,
	input  kmp_rd_t    rd,
	output kmp_entry_t rd_data
);

	kmp_entry_t mem [PATTERN_MAX];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data <= mem[rd.addr];
		end
	end

endmodule
`default_nettype wire

>>> src/kmp_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kmp_engine: table builder and text matcher
// Holds the search state and walks the failure chain in the table memory,
// one entry per cycle, for both pattern and text words.
// ----------------------------------------------------------------------------
module kmp_engine import kmp_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        item_valid,
	output logic       item_ready,
	input  kmp_item_t  item,
	output logic       res_valid,
	input  wire        res_ready,
	output kmp_res_t   res,
	output kmp_wr_t    wr,
	output kmp_rd_t    rd,
	input  kmp_entry_t rd_data
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_WALK = 3'b010,
		S_DONE = 3'b100
	} eng_state_t;

	eng_state_t state_q;
	cnt_t       count_q;
	fail_t      prefix_q;
	idx_t       match_q;
	pos_t       tpos_q;
	logic       found_q;
	logic       is_pat_q;
	sym_t       last_sym_q;
	sym_t       key_q;
	sym_t       wsym_q;
	fail_t      cur_q;
	kmp_res_t   res_q;

	logic  accept;
	cnt_t  count_eff;
	fail_t prefix_eff;
	logic  found_eff;
	idx_t  match_eff;
	idx_t  t_start;
	logic  hit;
	logic  fin;
	fail_t fin_r;
	cnt_t  fin_next;
	cnt_t  back;
	pos_t  match_pos;

	assign accept     = item_valid && (state_q == S_IDLE);
	assign item_ready = (state_q == S_IDLE);
	assign res_valid  = (state_q == S_DONE);
	assign res        = res_q;

	assign count_eff  = (item.mode == MODE_PATTERN && item.restart) ? '0 : count_q;
	assign prefix_eff = item.restart ? FAIL_NONE : prefix_q;
	assign found_eff  = item.restart ? 1'b0 : found_q;
	assign match_eff  = item.restart ? '0 : match_q;
	assign t_start    = (CNT_W'(match_eff) < count_q) ? match_eff : '0;

	assign hit = (rd_data.sym == key_q);

	// Step taken during a walk on the entry read last cycle.
	always_comb begin
		fin   = 1'b0;
		fin_r = FAIL_NONE;
		if (state_q == S_WALK) begin
			fin   = hit || rd_data.fail[IDX_W];
			fin_r = hit ? cur_q : rd_data.fail;
		end
	end

	assign fin_next = fin_r[IDX_W] ? '0 : CNT_W'(fin_r[IDX_W-1:0]) + CNT_W'(1);

	assign back      = count_q - CNT_W'(1);
	assign match_pos = (tpos_q >= POSITION_BITS'(back)) ? tpos_q - POSITION_BITS'(back) : '0;

	always_comb begin
		rd      = '0;
		wr      = '0;
		wr.addr = count_q[IDX_W-1:0];
		if (accept) begin
			wr.addr     = count_eff[IDX_W-1:0];
			wr.data.sym = item.symbol;
			if (item.mode == MODE_PATTERN) begin
				if (count_eff == '0) begin
					wr.en        = 1'b1;
					wr.data.fail = FAIL_NONE;
				end else if (count_eff != COUNT_MAX && prefix_eff[IDX_W]) begin
					wr.en        = 1'b1;
					wr.data.fail = '0;
				end else if (count_eff != COUNT_MAX) begin
					rd.en   = 1'b1;
					rd.addr = prefix_eff[IDX_W-1:0];
				end
			end else if (item.mode == MODE_TEXT && !found_eff && count_q != '0) begin
				rd.en   = 1'b1;
				rd.addr = t_start;
			end
		end else if (state_q == S_WALK) begin
			wr.data.sym  = wsym_q;
			wr.data.fail = fail_t'(fin_next);
			if (fin) begin
				wr.en = is_pat_q;
			end else begin
				rd.en   = 1'b1;
				rd.addr = rd_data.fail[IDX_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			prefix_q <= FAIL_NONE;
			match_q  <= '0;
			tpos_q   <= '0;
			found_q  <= 1'b0;
			is_pat_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (item.mode)
							MODE_PATTERN: begin
								match_q <= '0;
								tpos_q  <= '0;
								found_q <= 1'b0;
								if (item.restart) begin
									count_q  <= '0;
									prefix_q <= FAIL_NONE;
								end
								if (count_eff == COUNT_MAX) begin
									state_q <= S_DONE;
								end else if (count_eff == '0) begin
									count_q  <= CNT_W'(1);
									prefix_q <= FAIL_NONE;
									state_q  <= S_DONE;
								end else if (prefix_eff[IDX_W]) begin
									count_q  <= count_q + CNT_W'(1);
									prefix_q <= '0;
									state_q  <= S_DONE;
								end else begin
									is_pat_q <= 1'b1;
									state_q  <= S_WALK;
								end
							end
							MODE_TEXT, MODE_END: begin
								if (item.restart) begin
									match_q <= '0;
									tpos_q  <= '0;
									found_q <= 1'b0;
								end
								if (!found_eff && count_q == '0) begin
									found_q <= 1'b1;
									state_q <= S_DONE;
								end else if (!found_eff && item.mode == MODE_TEXT) begin
									is_pat_q <= 1'b0;
									state_q  <= S_WALK;
								end else begin
									state_q <= S_DONE;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_WALK: begin
					if (fin) begin
						state_q <= S_DONE;
						if (is_pat_q) begin
							count_q  <= count_q + CNT_W'(1);
							prefix_q <= fail_t'(fin_next);
						end else begin
							if (fin_next >= count_q) begin
								found_q <= 1'b1;
								match_q <= '0;
							end else begin
								match_q <= fin_next[IDX_W-1:0];
							end
							if (tpos_q != '1) begin
								tpos_q <= tpos_q + POSITION_BITS'(1);
							end
						end
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers: walk operands and the pending result.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					res_q.position <= '0;
					res_q.status   <= ST_NO_MATCH;
					cur_q          <= {1'b0, t_start};
					key_q          <= item.symbol;
					wsym_q         <= item.symbol;
					case (item.mode)
						MODE_PATTERN: begin
							key_q <= last_sym_q;
							cur_q <= prefix_eff;
							if (count_eff == COUNT_MAX) begin
								res_q.status <= ST_OVERFLOW;
							end else begin
								res_q.status <= ST_PATTERN_OK;
								if (count_eff == '0 || prefix_eff[IDX_W]) begin
									last_sym_q <= item.symbol;
								end
							end
						end
						MODE_TEXT, MODE_END: begin
							if (found_eff) begin
								res_q.status <= ST_ALREADY;
							end else if (count_q == '0) begin
								res_q.status <= ST_MATCH;
							end else if (item.mode == MODE_END) begin
								res_q.status <= ST_NOT_FOUND;
							end
						end
						default: begin
							res_q.status <= ST_NO_MATCH;
						end
					endcase
				end
			end
			S_WALK: begin
				if (fin) begin
					if (is_pat_q) begin
						res_q.status <= ST_PATTERN_OK;
						last_sym_q   <= wsym_q;
					end else if (fin_next >= count_q) begin
						res_q.status   <= ST_MATCH;
						res_q.position <= match_pos;
					end else begin
						res_q.status <= ST_NO_MATCH;
					end
				end else begin
					cur_q <= rd_data.fail;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

>>> verif/tb_kmp_substring_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kmp_substring_search: self-checking bench for the substring search block
// Pattern and text words are streamed in with random gaps and the report
// words are taken with random stalls. A behavioural copy of the search
// (failure-table build and matching) runs on every accepted word, and each
// report that comes out is compared with the oldest prediction in order.
// ----------------------------------------------------------------------------
module tb_kmp_substring_search;
	import kmp_pkg::*;

	// Mode 3 has no meaning in the block; it must be ignored and answered
	// with a plain "no match yet" report.
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// Highest value the text position counter can hold before it saturates.
	localparam longint unsigned POS_LIMIT = (64'd1 << POSITION_BITS) - 64'd1;

	// Least number of randomly built words to send after the directed part.
	localparam int RANDOM_WORDS = 650;

	// Report index at which the receiver pauses for a long stretch, and how
	// long it pauses, so that the block backs up and drops s_tready.
	localparam int HOLD_AT     = 40;
	localparam int HOLD_CYCLES = 400;

	// ------------------------------------------------------------------------
	// Prediction of the search and the queue of reports still to come.
	// ------------------------------------------------------------------------
	class search_tracker;
		logic [SYMBOL_BITS-1:0] pat_sym [PATTERN_MAX];
		int                     fail_link [PATTERN_MAX];
		int                     pat_len;
		int                     prefix_len;
		int                     text_idx;
		longint unsigned        text_pos;
		bit                     found;
		kmp_res_t               reports [$];
		int                     errors;

		function new();
			pat_len    = 0;
			prefix_len = -1;
			text_idx   = 0;
			text_pos   = 0;
			found      = 1'b0;
			errors     = 0;
		endfunction

		function void clear_search();
			text_idx = 0;
			text_pos = 0;
			found    = 1'b0;
		endfunction

		// Advances the search by one accepted input word and queues the
		// report that this word must produce.
		function void take_word(logic [1:0] mode, logic [7:0] symbol, logic restart);
			logic [SYMBOL_BITS-1:0] sym;
			logic [SYMBOL_BITS-1:0] prev;
			kmp_res_t               rep;
			longint unsigned        back;
			longint unsigned        pos;
			int                     f;
			int                     t;

			sym = symbol[SYMBOL_BITS-1:0];
			rep.status = ST_NO_MATCH;
			pos = 0;
			case (mode)
				MODE_PATTERN: begin
					if (restart) begin
						pat_len    = 0;
						prefix_len = -1;
					end
					// Any pattern word, stored or refused, restarts the search.
					clear_search();
					if (pat_len >= PATTERN_MAX) begin
						rep.status = ST_OVERFLOW;
					end else begin
						pat_sym[pat_len] = sym;
						if (pat_len == 0) begin
							fail_link[0] = -1;
							prefix_len   = -1;
						end else begin
							// Extend the longest border of the prefix seen so far.
							f    = prefix_len;
							prev = pat_sym[pat_len-1];
							while (f >= 0 && pat_sym[f] != prev)
								f = fail_link[f];
							f++;
							fail_link[pat_len] = f;
							prefix_len         = f;
						end
						pat_len++;
						rep.status = ST_PATTERN_OK;
					end
				end
				MODE_TEXT, MODE_END: begin
					if (restart)
						clear_search();
					if (found) begin
						rep.status = ST_ALREADY;
					end else if (pat_len == 0) begin
						// An empty pattern matches straight away at the start.
						found      = 1'b1;
						rep.status = ST_MATCH;
					end else if (mode == MODE_END) begin
						rep.status = ST_NOT_FOUND;
					end else begin
						t = text_idx;
						if (t < 0 || t >= pat_len)
							t = 0;
						while (t >= 0 && pat_sym[t] != sym)
							t = fail_link[t];
						t++;
						if (t >= pat_len) begin
							back       = longint'(pat_len - 1);
							found      = 1'b1;
							rep.status = ST_MATCH;
							pos        = (text_pos >= back) ? text_pos - back : 0;
							text_idx   = 0;
						end else begin
							text_idx   = t;
						end
						if (text_pos < POS_LIMIT)
							text_pos++;
					end
				end
				default: begin
					// Unused mode: no change of state.
				end
			endcase
			rep.position = pos_t'(pos & POS_LIMIT);
			reports.push_back(rep);
		endfunction

		// Compares one report word taken from the block with the oldest
		// prediction.
		function void check_report(logic [2:0] status, logic [31:0] position);
			kmp_res_t want;

			if (reports.size() == 0) begin
				$error("report word with nothing pending: status %0d match_position %0d",
					status, position);
				errors++;
				return;
			end
			want = reports.pop_front();
			if (status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, status);
				errors++;
			end
			if (position !== 32'(want.position)) begin
				$error("match_position: expected %0d, got %0d", want.position, position);
				errors++;
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset and the block under test.
	// ------------------------------------------------------------------------
	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;    // symbol[7:0], restart[8], zero[15:9]
	logic [1:0]  s_tuser  = '0;    // mode[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;          // match_position[31:0]
	logic [2:0]  m_tuser;          // status[2:0]

	search_tracker sb = new();

	kmp_substring_search dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Reset is held and then let go on a falling edge, well away from the
	// edge at which the block's registers update.
	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// Draws the idle cycles before the next word on either side. Now and then
	// a run of back-to-back words is started so that full-rate traffic is
	// also seen.
	function automatic int next_gap(inout int quiet_left);
		if (quiet_left > 0) begin
			quiet_left--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0)
			quiet_left = $urandom_range(10, 30);
		return $urandom_range(0, 15);
	endfunction

	// ------------------------------------------------------------------------
	// Sender. Called at a rising edge; returns at the rising edge at which
	// the word was accepted, with s_tvalid still high. The ready level that
	// counts for an edge is sampled on the falling edge before it, so the
	// handshake never depends on the order of events within a time step.
	// ------------------------------------------------------------------------
	int send_quiet = 0;

	task automatic send_word(input logic [1:0] mode, input logic [7:0] symbol,
			input logic restart);
		int gap;
		bit took;

		gap = next_gap(send_quiet);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'b0, restart, symbol};
		s_tuser  <= mode;
		do begin
			@(negedge clk);
			took = s_tready;
			@(posedge clk);
		end while (!took);
		sb.take_word(mode, symbol, restart);
	endtask

	// ------------------------------------------------------------------------
	// Stimulus: a short directed part, then random search rounds. Each round
	// loads a pattern over a small alphabet so that partial matches and long
	// fall-backs are common, then streams text over the same alphabet, often
	// with the pattern planted in it. A few noise words sit between rounds.
	// ------------------------------------------------------------------------
	initial begin
		logic [7:0] alph [3];
		logic [7:0] pat_q [$];
		logic [7:0] txt_q [$];
		int         alph_n;
		int         counted;
		int         round;
		int         plen;
		int         tlen;
		int         at;
		bit         long_pat;
		bit         fresh;
		bit         rs;

		counted = 0;
		round   = 0;
		@(posedge arst_n);
		@(posedge clk);

		// Straight after reset the pattern is empty, so the first text word
		// matches at position 0; later words say the match is already found,
		// and a restarted end of text matches the empty pattern again.
		send_word(MODE_TEXT, 8'h00, 1'b0);
		send_word(MODE_END, 8'h00, 1'b0);
		send_word(MODE_END, 8'hFF, 1'b1);
		// The unused mode is ignored.
		send_word(MODE_UNUSED, 8'hFF, 1'b1);
		// Pattern FF 00 FF found inside 00 FF 00 FF at position 1.
		send_word(MODE_PATTERN, 8'hFF, 1'b1);
		send_word(MODE_PATTERN, 8'h00, 1'b0);
		send_word(MODE_PATTERN, 8'hFF, 1'b0);
		send_word(MODE_TEXT, 8'h00, 1'b1);
		send_word(MODE_TEXT, 8'hFF, 1'b0);
		send_word(MODE_TEXT, 8'h00, 1'b0);
		send_word(MODE_TEXT, 8'hFF, 1'b0);
		send_word(MODE_END, 8'h00, 1'b0);
		// Restarted end of text with no text at all: not found.
		send_word(MODE_END, 8'h00, 1'b1);
		// A pattern word in the middle of a search appends to the pattern and
		// throws the search away, so the next text starts at position 0.
		send_word(MODE_TEXT, 8'hFF, 1'b1);
		send_word(MODE_PATTERN, 8'h00, 1'b0);
		send_word(MODE_TEXT, 8'hFF, 1'b0);
		send_word(MODE_TEXT, 8'h00, 1'b0);
		send_word(MODE_TEXT, 8'hFF, 1'b0);
		send_word(MODE_TEXT, 8'h00, 1'b0);
		send_word(MODE_END, 8'hFF, 1'b0);
		// End of text leaves the search where it is; the text then goes on
		// and completes the match at position 0.
		send_word(MODE_TEXT, 8'hFF, 1'b1);
		send_word(MODE_END, 8'h00, 1'b0);
		send_word(MODE_TEXT, 8'h00, 1'b0);
		send_word(MODE_TEXT, 8'hFF, 1'b0);
		send_word(MODE_TEXT, 8'h00, 1'b0);

		while (counted < RANDOM_WORDS) begin
			if ($urandom_range(0, 9) == 0)
				send_word(MODE_UNUSED, 8'($urandom), 1'($urandom));
			if ($urandom_range(0, 9) == 0) begin
				send_word(2'($urandom_range(0, 2)), 8'($urandom), 1'($urandom));
				counted++;
			end

			alph_n = $urandom_range(1, 3);
			foreach (alph[k])
				alph[k] = 8'($urandom);

			// Round 3 and a few others fill the pattern store and push past
			// its end, so that the overflow refusal is exercised.
			long_pat = (round == 3) || ($urandom_range(0, 14) == 0);
			plen = long_pat ? PATTERN_MAX + $urandom_range(1, 3) : $urandom_range(1, 6);
			pat_q.delete();
			for (int k = 0; k < plen; k++)
				pat_q.push_back(alph[$urandom_range(0, alph_n - 1)]);
			// Mostly a fresh pattern; otherwise the words extend the old one.
			fresh = ($urandom_range(0, 7) != 0);
			for (int k = 0; k < plen; k++) begin
				send_word(MODE_PATTERN, pat_q[k], fresh && k == 0);
				counted++;
			end

			tlen = long_pat ? $urandom_range(60, 90) : $urandom_range(0, 30);
			txt_q.delete();
			for (int k = 0; k < tlen; k++) begin
				if ($urandom_range(0, 29) == 0)
					txt_q.push_back(8'($urandom));
				else
					txt_q.push_back(alph[$urandom_range(0, alph_n - 1)]);
			end
			if ($urandom_range(0, 2) == 0 && tlen >= plen) begin
				at = $urandom_range(0, tlen - plen);
				for (int k = 0; k < plen; k++)
					txt_q[at + k] = pat_q[k];
			end
			for (int k = 0; k < tlen; k++) begin
				// An end of text in the middle must not disturb the search.
				if ($urandom_range(0, 24) == 0) begin
					send_word(MODE_END, 8'($urandom), 1'b0);
					counted++;
				end
				rs = (k == 0 && $urandom_range(0, 3) != 0) || ($urandom_range(0, 39) == 0);
				send_word(MODE_TEXT, txt_q[k], rs);
				counted++;
			end
			if ($urandom_range(0, 3) != 0) begin
				send_word(MODE_END, 8'($urandom), $urandom_range(0, 9) == 0);
				counted++;
			end
			round++;
		end
		s_tvalid <= 1'b0;

		// Drain the outstanding reports, then give the block time to show
		// any stray word it should not produce.
		while (sb.reports.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		if (sb.errors == 0 && sb.reports.size() == 0) begin
			$display("tb_kmp_substring_search: done, clean");
		end else begin
			$display("tb_kmp_substring_search: done, errors");
		end
		$finish;
	end

	// ------------------------------------------------------------------------
	// Receiver. Takes report words with random stalls; once, early in the
	// run, it stops for a long stretch while the sender keeps offering words,
	// so that the output register and the engine both fill up.
	// ------------------------------------------------------------------------
	initial begin
		int         gap;
		int         quiet;
		int         seen;
		bit         took;
		logic [2:0] status;
		logic [31:0] position;

		quiet = 0;
		seen  = 0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (seen == HOLD_AT) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				gap = next_gap(quiet);
				if (gap != 0) begin
					m_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			do begin
				@(negedge clk);
				took     = m_tvalid;
				status   = m_tuser;
				position = m_tdata;
				@(posedge clk);
			end while (!took);
			sb.check_report(status, position);
			seen++;
		end
	end

	// Guard against a hung handshake. A correct run needs well under a tenth
	// of this.
	initial begin
		#5_000_000;
		$display("tb_kmp_substring_search: done, errors");
		$finish;
	end

endmodule

>>> files.f
src/kmp_pkg.sv
src/kmp_ram.sv
src/kmp_engine.sv
src/kmp_substring_search.sv
verif/tb_kmp_substring_search.sv
